/* src/rrs_pkg.sv */
// rrs_pkg: shared types and constants for the round-robin slice scheduler
// no dependencies; imported by round_robin_slice_scheduler
`timescale 1ns / 1ps

package rrs_pkg;

    // field widths
    localparam int MODE_W  = 2;
    localparam int ID_W    = 22;
    localparam int SHARE_W = 16;
    localparam int EVENT_W = 3;
    localparam int SLOT_W  = 7;
    localparam int TICKS_W = 13;

    // command codes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // share / 10 as multiply by reciprocal, exact for any 16-bit share
    localparam int              RECIP_W     = 32;
    localparam logic [SHARE_W-1:0] RECIP_10 = 16'd52429;
    localparam int              RECIP_SHIFT = 19;

    // result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_START     = 3'd0,
        EV_STOP      = 3'd1,
        EV_ADDED     = 3'd2,
        EV_FULL      = 3'd3,
        EV_REMOVED   = 3'd4,
        EV_NOT_FOUND = 3'd5
    } event_t;

    // one table word: valid mark, share and process id
    typedef struct packed {
        logic               valid;
        logic [SHARE_W-1:0] share;
        logic [ID_W-1:0]    id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/rrs_ram.sv */
// rrs_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/round_robin_slice_scheduler.sv */
// round_robin_slice_scheduler: client table with round-robin time slices
// depends on rrs_pkg and rrs_ram (table of id, share and valid mark)
// add: result registered in the cycle after the transfer, busy stays low (next item the cycle after)
// remove: busy while the table is scanned from slot 0 for the id, one result at the end
// tick: busy while the table is scanned (one table read per cycle); any results come stop then start
// reset (rst_n low, async) empties the table and ends any running slice; no clearing pass
`timescale 1ns / 1ps

module round_robin_slice_scheduler #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rrs_pkg::MODE_W-1:0]  mode,
    input  logic [rrs_pkg::ID_W-1:0]    client_pid,
    input  logic [rrs_pkg::SHARE_W-1:0] share,
    output logic                        res_valid,
    output logic [rrs_pkg::EVENT_W-1:0] event_res,
    output logic [rrs_pkg::ID_W-1:0]    client_id,
    output logic [rrs_pkg::SLOT_W-1:0]  slot,
    output logic                        last
);

    import rrs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_STOP_RD,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic                op_remove_reg;
    logic [ID_W-1:0]     pid_reg;

    // scheduler state
    logic [CNT_W-1:0]    entry_count_reg;
    logic [ADDR_W-1:0]   rotate_reg;
    logic                active_reg;
    logic [TICKS_W-1:0]  ticks_reg;
    logic [ADDR_W-1:0]   active_slot_reg;

    // scan pipeline
    logic [ADDR_W-1:0]   pos_reg;
    logic [CNT_W-1:0]    issue_cnt_reg;
    logic                pend_reg;
    logic [ADDR_W-1:0]   pend_slot_reg;
    logic                pend_last_reg;

    // held results of a tick
    logic                stop_pend_reg;
    logic [ID_W-1:0]     stop_id_reg;
    logic [ADDR_W-1:0]   stop_slot_reg;
    logic                start_pend_reg;
    logic [ID_W-1:0]     start_id_reg;
    logic [ADDR_W-1:0]   start_slot_reg;

    // registered result
    logic                res_valid_reg;
    event_t              event_reg;
    logic [ID_W-1:0]     client_reg;
    logic [ADDR_W-1:0]   slot_reg;
    logic                last_reg;

    // ram interface
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;
    entry_t              wr_entry;

    logic                accept;
    logic                table_full;
    logic                issue;
    logic                hit;
    logic [CNT_W-1:0]    pos_inc;
    logic [ADDR_W-1:0]   pos_wrap;
    logic [CNT_W-1:0]    pend_inc;
    logic [ADDR_W-1:0]   pend_wrap;
    logic [RECIP_W-1:0]  prod;
    logic [TICKS_W-1:0]  quot;

    rrs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_entry   = entry_t'(ram_rdata);
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && (state_reg == ST_IDLE);
    assign table_full = (entry_count_reg == CNT_W'(TABLE_DEPTH));

    // scan address stepping, wraps at the fill count
    assign pos_inc   = CNT_W'(pos_reg) + CNT_W'(1);
    assign pos_wrap  = (pos_inc >= entry_count_reg) ? '0 : pos_inc[ADDR_W-1:0];
    assign pend_inc  = CNT_W'(pend_slot_reg) + CNT_W'(1);
    assign pend_wrap = (pend_inc >= entry_count_reg) ? '0 : pend_inc[ADDR_W-1:0];
    assign issue     = (state_reg == ST_SCAN) && (issue_cnt_reg < entry_count_reg);

    // entry returned by the ram this cycle qualifies
    assign hit = (state_reg == ST_SCAN) && pend_reg && rd_entry.valid
                 && (!op_remove_reg || (rd_entry.id == pid_reg));

    // slice length from the share read out of the table
    assign prod = RECIP_W'(rd_entry.share) * RECIP_W'(RECIP_10);
    assign quot = prod[RECIP_SHIFT +: TICKS_W];

    // table writes: append on add, clear the valid mark on remove
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = entry_count_reg[ADDR_W-1:0];
        wr_entry.valid = 1'b1;
        wr_entry.share = share;
        wr_entry.id    = client_pid;
        if (accept && (mode == MODE_ADD) && !table_full)
        begin
            ram_we = 1'b1;
        end
        else if (hit && op_remove_reg)
        begin
            ram_we         = 1'b1;
            ram_waddr      = pend_slot_reg;
            wr_entry.valid = 1'b0;
            wr_entry.share = rd_entry.share;
            wr_entry.id    = rd_entry.id;
        end
    end

    assign ram_wdata = wr_entry;

    // read address: running entry on a slice end, scan position otherwise
    always_comb
    begin
        case (state_reg)
            ST_TICK: ram_raddr = active_slot_reg;
            default: ram_raddr = pos_reg;
        endcase
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_remove_reg   <= 1'b0;
            entry_count_reg <= '0;
            rotate_reg      <= '0;
            active_reg      <= 1'b0;
            ticks_reg       <= '0;
            active_slot_reg <= '0;
            issue_cnt_reg   <= '0;
            pend_reg        <= 1'b0;
            stop_pend_reg   <= 1'b0;
            start_pend_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
            last_reg        <= 1'b0;
            event_reg       <= EV_START;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pid_reg <= client_pid;
                        case (mode)
                            MODE_TICK:
                            begin
                                op_remove_reg <= 1'b0;
                                state_reg     <= ST_TICK;
                            end
                            MODE_ADD:
                            begin
                                res_valid_reg <= 1'b1;
                                last_reg      <= 1'b1;
                                client_reg    <= client_pid;
                                if (table_full)
                                begin
                                    event_reg <= EV_FULL;
                                    slot_reg  <= '0;
                                end
                                else
                                begin
                                    event_reg       <= EV_ADDED;
                                    slot_reg        <= entry_count_reg[ADDR_W-1:0];
                                    entry_count_reg <= entry_count_reg + CNT_W'(1);
                                end
                            end
                            MODE_REMOVE:
                            begin
                                op_remove_reg <= 1'b1;
                                state_reg     <= ST_SCAN_INIT;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // count down the running slice, or go to the scan when none runs
                ST_TICK:
                begin
                    if (active_reg)
                    begin
                        if (ticks_reg <= TICKS_W'(1))
                        begin
                            active_reg    <= 1'b0;
                            ticks_reg     <= '0;
                            stop_pend_reg <= 1'b1;
                            state_reg     <= ST_STOP_RD;
                        end
                        else
                        begin
                            ticks_reg <= ticks_reg - TICKS_W'(1);
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_SCAN_INIT;
                    end
                end

                // id of the finished client arrives from the table
                ST_STOP_RD:
                begin
                    stop_id_reg   <= rd_entry.id;
                    stop_slot_reg <= active_slot_reg;
                    state_reg     <= ST_SCAN_INIT;
                end

                ST_SCAN_INIT:
                begin
                    issue_cnt_reg <= '0;
                    pend_reg      <= 1'b0;
                    if (op_remove_reg || (CNT_W'(rotate_reg) >= entry_count_reg))
                    begin
                        pos_reg <= '0;
                    end
                    else
                    begin
                        pos_reg <= rotate_reg;
                    end
                    if (entry_count_reg == '0)
                    begin
                        if (op_remove_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            last_reg      <= 1'b1;
                            event_reg     <= EV_NOT_FOUND;
                            client_reg    <= pid_reg;
                            slot_reg      <= '0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end

                // one read issued and one entry checked per cycle
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        pos_reg       <= pos_wrap;
                        issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                    end
                    pend_reg      <= issue;
                    pend_slot_reg <= pos_reg;
                    pend_last_reg <= (issue_cnt_reg + CNT_W'(1) == entry_count_reg);

                    if (hit)
                    begin
                        pend_reg <= 1'b0;
                        if (op_remove_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            last_reg      <= 1'b1;
                            event_reg     <= EV_REMOVED;
                            client_reg    <= pid_reg;
                            slot_reg      <= pend_slot_reg;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            start_pend_reg  <= 1'b1;
                            start_id_reg    <= rd_entry.id;
                            start_slot_reg  <= pend_slot_reg;
                            active_reg      <= 1'b1;
                            active_slot_reg <= pend_slot_reg;
                            ticks_reg       <= (quot == '0) ? TICKS_W'(1) : quot;
                            rotate_reg      <= pend_wrap;
                            state_reg       <= ST_EMIT;
                        end
                    end
                    else if (pend_reg && pend_last_reg)
                    begin
                        pend_reg <= 1'b0;
                        if (op_remove_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            last_reg      <= 1'b1;
                            event_reg     <= EV_NOT_FOUND;
                            client_reg    <= pid_reg;
                            slot_reg      <= '0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end

                // stop first, then start, one per cycle
                ST_EMIT:
                begin
                    if (stop_pend_reg)
                    begin
                        stop_pend_reg <= 1'b0;
                        res_valid_reg <= 1'b1;
                        last_reg      <= !start_pend_reg;
                        event_reg     <= EV_STOP;
                        client_reg    <= stop_id_reg;
                        slot_reg      <= stop_slot_reg;
                        if (!start_pend_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (start_pend_reg)
                    begin
                        start_pend_reg <= 1'b0;
                        res_valid_reg  <= 1'b1;
                        last_reg       <= 1'b1;
                        event_reg      <= EV_START;
                        client_reg     <= start_id_reg;
                        slot_reg       <= start_slot_reg;
                        state_reg      <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign res_valid = res_valid_reg;
    assign event_res = event_reg;
    assign client_id = client_reg;
    assign slot      = SLOT_W'(slot_reg);
    assign last      = last_reg;

    // a running slice always has ticks left
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (ticks_reg != '0))
        else $error("active slice with zero ticks left");

    // fill count never passes the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // rotating pointer stays inside the filled part of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (entry_count_reg != '0) |-> (CNT_W'(rotate_reg) < entry_count_reg))
        else $error("rotate pointer outside filled entries");

    // a result that is not the last one is followed at once by another
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !last_reg) |=> res_valid_reg)
        else $error("non-final result not followed by another");

    // no table write while a tick scan reads the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ST_SCAN)) |-> op_remove_reg)
        else $error("table write during slice scan");

endmodule

/* tb/tb_round_robin_slice_scheduler.sv */
// tb_round_robin_slice_scheduler: self-checking testbench for the slice scheduler
// depends on rrs_pkg and round_robin_slice_scheduler; predicts every event in step
`timescale 1ns / 1ps

module tb_round_robin_slice_scheduler;
    import rrs_pkg::*;

    localparam int DEPTH       = 128;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_ITEMS = 375;
    localparam int MAX_REPORTS = 50;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [ID_W-1:0]   ID_MAX      = 22'h3FFFFF;
    localparam logic [ID_W-1:0]   ID_DUP      = 22'h2AAAAA;
    localparam logic [ID_W-1:0]   ID_LONG     = 22'h155555;

    typedef struct {
        event_t             ev;
        logic [ID_W-1:0]    id;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } sched_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     client_pid;
    logic [SHARE_W-1:0]  share;
    logic                res_valid;
    logic [EVENT_W-1:0]  event_res;
    logic [ID_W-1:0]     client_id;
    logic [SLOT_W-1:0]   slot;
    logic                last;

    // predicted scheduler state
    logic [ID_W-1:0]     client_ids [DEPTH];
    logic [SHARE_W-1:0]  client_shares [DEPTH];
    logic                client_live [DEPTH];
    int                  clients_added;
    int                  next_scan;
    logic                slice_running;
    int                  slice_ticks;
    int                  running_slot;

    sched_result_t       pending_events [$];
    sched_result_t       want;
    int                  fail_count;
    int                  cycle_count;
    int                  idle_pct;

    round_robin_slice_scheduler #(.TABLE_DEPTH(DEPTH)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .client_pid (client_pid),
        .share      (share),
        .res_valid  (res_valid),
        .event_res  (event_res),
        .client_id  (client_id),
        .slot       (slot),
        .last       (last)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("round_robin_slice_scheduler regression: fail");
            $finish;
        end
    end

    function automatic sched_result_t make_event(event_t ev, logic [ID_W-1:0] id,
                                                 logic [SLOT_W-1:0] s);
        sched_result_t r;
        r.ev   = ev;
        r.id   = id;
        r.slot = s;
        r.last = 1'b0;
        return r;
    endfunction

    // advance the predicted scheduler by one command and queue its events
    function automatic void predict_schedule(logic [MODE_W-1:0] m, logic [ID_W-1:0] pid,
                                             logic [SHARE_W-1:0] shr);
        sched_result_t evs [$];
        int pos;
        bit found;
        found = 0;
        if (m == MODE_TICK)
        begin
            if (slice_running)
            begin
                if (slice_ticks > 0)
                    slice_ticks--;
                if (slice_ticks == 0)
                begin
                    slice_running = 1'b0;
                    evs.push_back(make_event(EV_STOP, client_ids[running_slot],
                                             running_slot[SLOT_W-1:0]));
                end
            end
            // scan from the rotating pointer for the next live client
            if (!slice_running && clients_added > 0)
            begin
                pos = (next_scan >= clients_added) ? 0 : next_scan;
                for (int n = 0; n < clients_added && !found; n++)
                begin
                    if (client_live[pos])
                    begin
                        found         = 1;
                        slice_running = 1'b1;
                        running_slot  = pos;
                        slice_ticks   = client_shares[pos] / 10;
                        if (slice_ticks == 0)
                            slice_ticks = 1;
                        next_scan = (pos + 1 >= clients_added) ? 0 : pos + 1;
                        evs.push_back(make_event(EV_START, client_ids[pos],
                                                 pos[SLOT_W-1:0]));
                    end
                    else
                    begin
                        pos = (pos + 1 >= clients_added) ? 0 : pos + 1;
                    end
                end
            end
        end
        else if (m == MODE_ADD)
        begin
            if (clients_added >= DEPTH)
                evs.push_back(make_event(EV_FULL, pid, '0));
            else
            begin
                client_ids[clients_added]    = pid;
                client_shares[clients_added] = shr;
                client_live[clients_added]   = 1'b1;
                evs.push_back(make_event(EV_ADDED, pid, clients_added[SLOT_W-1:0]));
                clients_added++;
            end
        end
        else if (m == MODE_REMOVE)
        begin
            for (int i = 0; i < clients_added && !found; i++)
            begin
                if (client_live[i] && client_ids[i] == pid)
                begin
                    found          = 1;
                    client_live[i] = 1'b0;
                    evs.push_back(make_event(EV_REMOVED, pid, i[SLOT_W-1:0]));
                end
            end
            if (!found)
                evs.push_back(make_event(EV_NOT_FOUND, pid, '0));
        end
        if (evs.size() > 0)
            evs[$].last = 1'b1;
        foreach (evs[i])
            pending_events.push_back(evs[i]);
    endfunction

    // id of a random live client, or a random id when none is live
    function automatic logic [ID_W-1:0] pick_live_id();
        int live_slots [$];
        for (int i = 0; i < clients_added; i++)
            if (client_live[i])
                live_slots.push_back(i);
        if (live_slots.size() == 0)
            return ID_W'($urandom);
        return client_ids[live_slots[$urandom_range(0, live_slots.size() - 1)]];
    endfunction

    // one command transfer, then an optional sender gap
    task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] pid,
                            input logic [SHARE_W-1:0] shr);
        start      <= 1'b1;
        mode       <= m;
        client_pid <= pid;
        share      <= shr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_schedule(m, pid, shr);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    // result checker
    function automatic void report_field(string field, int unsigned exp_v,
                                         int unsigned act_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid)
        begin
            if (pending_events.size() == 0)
                report_field("unexpected result event_res", 0, event_res);
            else
            begin
                want = pending_events.pop_front();
                if (event_res !== want.ev)
                    report_field("event_res", want.ev, event_res);
                if (client_id !== want.id)
                    report_field("client_id", want.id, client_id);
                if (slot !== want.slot)
                    report_field("slot", want.slot, slot);
                if (last !== want.last)
                    report_field("last", want.last, last);
            end
        end
    end

    // ticks and unknown commands on an empty table give nothing
    task automatic test_empty_table();
        send_cmd(MODE_TICK, '0, '0);
        send_cmd(MODE_UNUSED, ID_MAX, '1);
        send_cmd(MODE_TICK, ID_MAX, '1);
    endtask

    // zero-share, short and exact slices rotating through the table
    task automatic test_short_slices();
        send_cmd(MODE_ADD, '0, 16'd0);
        send_cmd(MODE_ADD, ID_MAX, 16'd9);
        send_cmd(MODE_ADD, ID_W'($urandom), 16'd10);
        send_cmd(MODE_ADD, ID_W'($urandom), 16'd25);
        repeat (6) send_cmd(MODE_TICK, '0, '0);
    endtask

    // not found, duplicate ids, removal of the running client, unused long share
    task automatic test_remove_cases();
        send_cmd(MODE_REMOVE, ID_W'($urandom), '0);
        send_cmd(MODE_ADD, ID_DUP, 16'd15);
        send_cmd(MODE_ADD, ID_DUP, 16'd15);
        send_cmd(MODE_REMOVE, ID_DUP, '0);
        send_cmd(MODE_REMOVE, slice_running ? client_ids[running_slot] : client_ids[0], '0);
        repeat (3) send_cmd(MODE_TICK, '0, '0);
        send_cmd(MODE_ADD, ID_LONG, 16'hFFFF);
        send_cmd(MODE_REMOVE, ID_LONG, '0);
        send_cmd(MODE_TICK, '0, '0);
    endtask

    // mostly ticks with adds, removes (mostly of live clients) and unused commands mixed in
    task automatic test_random_traffic(input int count);
        int pick;
        logic [ID_W-1:0] pid;
        logic [SHARE_W-1:0] shr;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            shr  = ($urandom_range(0, 4) == 0) ? SHARE_W'($urandom_range(0, 255))
                                              : SHARE_W'($urandom_range(0, 39));
            if (pick < 72)
                send_cmd(MODE_TICK, ID_W'($urandom), SHARE_W'($urandom));
            else if (pick < 84)
            begin
                pid = ($urandom_range(0, 4) == 0) ? pick_live_id() : ID_W'($urandom);
                send_cmd(MODE_ADD, pid, shr);
            end
            else if (pick < 97)
            begin
                pid = ($urandom_range(0, 9) < 6) ? pick_live_id() : ID_W'($urandom);
                send_cmd(MODE_REMOVE, pid, SHARE_W'($urandom));
            end
            else
                send_cmd(MODE_UNUSED, ID_W'($urandom), SHARE_W'($urandom));
        end
    endtask

    // fill what is left of the table, then adds are rejected
    task automatic test_table_full();
        while (clients_added < DEPTH)
            send_cmd(MODE_ADD, ID_W'($urandom), SHARE_W'($urandom_range(0, 39)));
        send_cmd(MODE_ADD, ID_MAX, '1);
        send_cmd(MODE_ADD, ID_W'($urandom), SHARE_W'($urandom));
        repeat (4) send_cmd(MODE_TICK, '0, '0);
    endtask

    initial
    begin
        start         <= 1'b0;
        mode          <= MODE_TICK;
        client_pid    <= '0;
        share         <= '0;
        rst_n         <= 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        idle_pct      = 0;
        clients_added = 0;
        next_scan     = 0;
        slice_running = 1'b0;
        slice_ticks   = 0;
        running_slot  = 0;
        foreach (client_live[i])
            client_live[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_short_slices();
        idle_pct = 66;
        test_remove_cases();

        // idle phases: none, sender 66%, receiver (cannot stall, so none), both (sender 17% only)
        idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS);
        idle_pct = 66;
        test_random_traffic(RANDOM_ITEMS);
        idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS);
        idle_pct = 17;
        test_random_traffic(RANDOM_ITEMS);
        test_table_full();

        // drain outstanding events, then let the block settle
        start <= 1'b0;
        for (int i = 0; i < 5000 && pending_events.size() != 0; i++)
            @(posedge clk);
        repeat (DEPTH + 20) @(posedge clk);
        if (pending_events.size() != 0)
            report_field("events never seen", 0, pending_events.size());

        if (fail_count == 0)
            $display("round_robin_slice_scheduler regression: pass");
        else
            $display("round_robin_slice_scheduler regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/rrs_pkg.sv
src/rrs_ram.sv
src/round_robin_slice_scheduler.sv
tb/tb_round_robin_slice_scheduler.sv
